[src/rtcc_pkg.sv]
// ============================================================================
// rtcc_pkg
// Shared types, constants and calendar functions for the time and date counter.
// ============================================================================
package rtcc_pkg;

   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;

   localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
   localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);
   localparam logic [MONTH_W-1:0]  MONTH_MAX  = MONTH_W'(12);
   localparam logic [MONTH_W-1:0]  MONTH_JAN  = MONTH_W'(1);
   localparam logic [DAY_W-1:0]    DAY_FIRST  = DAY_W'(1);

   // Last year before the counter wraps back to year zero.
   localparam logic [YEAR_W-1:0] LAST_YEAR  = YEAR_W'(9999);
   localparam logic [YEAR_W-1:0] RESET_YEAR = YEAR_W'(1996);

   // Divisibility by 25 through the modular inverse: for odd d, y is a
   // multiple of d exactly when (y * d^-1) mod 2^n is at most (2^n - 1) / d.
   localparam logic [YEAR_W-1:0] INV25       = YEAR_W'(7209);
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(((1 << YEAR_W) - 1) / 25);

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_SET  = 1'b1
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [HOUR_W-1:0]   set_hour;
      logic [MINUTE_W-1:0] set_minute;
      logic [SECOND_W-1:0] set_second;
      logic [YEAR_W-1:0]   set_year;
      logic [MONTH_W-1:0]  set_month;
      logic [DAY_W-1:0]    set_day;
   } req_word_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   now_hour;
      logic [MINUTE_W-1:0] now_minute;
      logic [SECOND_W-1:0] now_second;
      logic [YEAR_W-1:0]   now_year;
      logic [MONTH_W-1:0]  now_month;
      logic [DAY_W-1:0]    now_day;
      logic                day_rolled;
   } rsp_word_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
   } time_date_type;

   function automatic logic is_mult25(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      prod = YEAR_W'(year * INV25);
      return prod <= DIV25_LIMIT;
   endfunction

   // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic m25;
      m25 = is_mult25(year);
      return ((year[1:0] == 2'd0) && !m25) || ((year[3:0] == 4'd0) && m25);
   endfunction

   // Days in a month; zero for a month outside January to December.
   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0]  year,
                                                   input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:                                       len = is_leap(year) ? DAY_W'(29)
                                                                         : DAY_W'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

endpackage

[src/rtcc_if.sv]
// ============================================================================
// rtcc_req_if / rtcc_rsp_if
// Valid/ready channels carrying request and response words.
// ============================================================================
interface rtcc_req_if;
   logic                  valid;
   logic                  ready;
   rtcc_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface rtcc_rsp_if;
   logic                  valid;
   logic                  ready;
   rtcc_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

[src/time_and_date_counter.sv]
// ============================================================================
// time_and_date_counter
// Real-time clock with a Gregorian calendar, driven by tick and load words.
// ============================================================================
// Usage:
// Each request word on req_ch is either a one-second tick or a load of time
// and date. A load clamps out-of-range fields (bad hour, minute or second to
// zero, bad year to zero, bad month to January the first, bad day to the
// first). A tick carries seconds into minutes, hours and the calendar, with
// the Gregorian leap rule and a wrap to year zero after the last supported year.
// Every request word yields exactly one response word on rsp_ch holding the
// time and date after that request, plus a flag that is set when a tick
// crossed midnight.
// A word accepted on req_ch is registered in the input stage, and its
// response is then registered in the time and date register.
// Throughput: one word per cycle while rsp_ch is not stalled; the whole update is one
// pass of carry and compare logic plus two 14-bit constant multiplies for the leap
// tests, between the input register and the time and date register.
// Reset clears the time to 00:00:00 on January 1, 1996, and empties both
// stages. When the receiver stalls, the response word holds; the input stage
// still takes one more word, and then req_ch.ready drops until rsp_ch moves.
// ============================================================================
module time_and_date_counter (
   input logic              clock,
   input logic              reset,
   rtcc_req_if.sink         req_ch,
   rtcc_rsp_if.source       rsp_ch
);

   // Input stage.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   rtcc_pkg::req_word_type in_word_ff;

   // The time and date register doubles as the response payload: it only
   // changes when a new response is loaded, so it always matches rsp_ch.
   rtcc_pkg::time_date_type now_ff;
   rtcc_pkg::time_date_type now_in;
   logic                    rolled_ff;
   logic                    rolled_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;

   rtcc_pkg::time_date_type calc_nxt;
   logic                    calc_rolled;
   logic                    fire;

   // The word in the input stage is processed when the response register is
   // empty or is being emptied in this same cycle.
   assign fire          = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || fire;

   rtcc_calc u_calc (
      .word   (in_word_ff),
      .cur    (now_ff),
      .nxt    (calc_nxt),
      .rolled (calc_rolled)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      now_in       = now_ff;
      rolled_in    = rolled_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
         now_in       = calc_nxt;
         rolled_in    = calc_rolled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rolled_ff    <= 1'b0;
         now_ff       <= '{hour:   '0,
                           minute: '0,
                           second: '0,
                           year:   rtcc_pkg::RESET_YEAR,
                           month:  rtcc_pkg::MONTH_JAN,
                           day:    rtcc_pkg::DAY_FIRST};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rolled_ff    <= rolled_in;
         now_ff       <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_word_ff <= req_ch.word;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.word.now_hour   = now_ff.hour;
   assign rsp_ch.word.now_minute = now_ff.minute;
   assign rsp_ch.word.now_second = now_ff.second;
   assign rsp_ch.word.now_year   = now_ff.year;
   assign rsp_ch.word.now_month  = now_ff.month;
   assign rsp_ch.word.now_day    = now_ff.day;
   assign rsp_ch.word.day_rolled = rolled_ff;

   // The stored time of day never leaves its legal range.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      now_ff.hour <= rtcc_pkg::HOUR_MAX && now_ff.minute <= rtcc_pkg::MINUTE_MAX &&
      now_ff.second <= rtcc_pkg::SECOND_MAX)
      else $error("stored time of day out of range");

   // The stored date is always a real month, a day of at least one and a year no later than the last year.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      now_ff.month >= rtcc_pkg::MONTH_JAN && now_ff.month <= rtcc_pkg::MONTH_MAX &&
      now_ff.day >= rtcc_pkg::DAY_FIRST && now_ff.year <= rtcc_pkg::LAST_YEAR)
      else $error("stored date out of range");

   // A midnight crossing leaves the time at 00:00:00.
   a_roll_midnight: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rolled_ff |->
         now_ff.hour == '0 && now_ff.minute == '0 && now_ff.second == '0)
      else $error("day rolled but time is not midnight");

   // A tick that does not cross midnight leaves the date untouched.
   a_tick_keeps_date: assert property (@(posedge clock) disable iff (reset)
      fire && in_word_ff.action == rtcc_pkg::ACT_TICK && !calc_rolled |=>
         $stable(now_ff.year) && $stable(now_ff.month) && $stable(now_ff.day))
      else $error("date changed on a tick without midnight");

   // The state only moves when a response word is produced.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(now_ff) && $stable(rolled_ff))
      else $error("time and date changed without a response");

endmodule

[src/rtcc_calc.sv]
// ============================================================================
// rtcc_calc
// Next time and date for one request word: a one-second tick or a clamped load.
// ============================================================================
module rtcc_calc (
   input  rtcc_pkg::req_word_type  word,
   input  rtcc_pkg::time_date_type cur,
   output rtcc_pkg::time_date_type nxt,
   output logic                    rolled
);

   logic [rtcc_pkg::YEAR_W-1:0] load_year;
   logic [rtcc_pkg::DAY_W-1:0]  load_len;
   logic [rtcc_pkg::DAY_W-1:0]  cur_len;

   assign load_year = (word.set_year > rtcc_pkg::LAST_YEAR) ? '0 : word.set_year;
   assign load_len  = rtcc_pkg::month_len(load_year, word.set_month);
   assign cur_len   = rtcc_pkg::month_len(cur.year, cur.month);

   always_comb begin
      nxt    = cur;
      rolled = 1'b0;
      case (word.action)
         rtcc_pkg::ACT_SET: begin
            nxt.hour   = (word.set_hour > rtcc_pkg::HOUR_MAX) ? '0 : word.set_hour;
            nxt.minute = (word.set_minute > rtcc_pkg::MINUTE_MAX) ? '0 : word.set_minute;
            nxt.second = (word.set_second > rtcc_pkg::SECOND_MAX) ? '0 : word.set_second;
            nxt.year   = load_year;
            if (word.set_month == '0 || word.set_month > rtcc_pkg::MONTH_MAX) begin
               nxt.month = rtcc_pkg::MONTH_JAN;
               nxt.day   = rtcc_pkg::DAY_FIRST;
            end else begin
               nxt.month = word.set_month;
               nxt.day   = (word.set_day == '0 || word.set_day > load_len)
                           ? rtcc_pkg::DAY_FIRST : word.set_day;
            end
         end
         default: begin
            if (cur.second < rtcc_pkg::SECOND_MAX) begin
               nxt.second = cur.second + 1'b1;
            end else begin
               nxt.second = '0;
               if (cur.minute < rtcc_pkg::MINUTE_MAX) begin
                  nxt.minute = cur.minute + 1'b1;
               end else begin
                  nxt.minute = '0;
                  if (cur.hour < rtcc_pkg::HOUR_MAX) begin
                     nxt.hour = cur.hour + 1'b1;
                  end else begin
                     nxt.hour = '0;
                     rolled   = 1'b1;
                     // A stored day at or past the month's end counts as its last day.
                     if (cur.day < cur_len) begin
                        nxt.day = cur.day + 1'b1;
                     end else begin
                        nxt.day = rtcc_pkg::DAY_FIRST;
                        if (cur.month < rtcc_pkg::MONTH_MAX) begin
                           nxt.month = cur.month + 1'b1;
                        end else begin
                           nxt.month = rtcc_pkg::MONTH_JAN;
                           nxt.year  = (cur.year >= rtcc_pkg::LAST_YEAR)
                                       ? '0 : cur.year + 1'b1;
                        end
                     end
                  end
               end
            end
         end
      endcase
   end

endmodule
